/* rtl/bmfw_pkg.sv */
// ----------------------------------------------------------------------------
// bmfw_pkg
// Shared types, sizes and command codes for the boolean product / witness block.
// ----------------------------------------------------------------------------
package bmfw_pkg;

  // matrix size and number of witness products; fixed by the field widths
  localparam int DIM      = 16;
  localparam int PRODUCTS = 8;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_MULT   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CLEAR = 2'd1,
    ST_MULT  = 2'd2,
    ST_READ  = 2'd3
  } state_t;

endpackage

/* rtl/bmfw_front.sv */
// ----------------------------------------------------------------------------
// bmfw_front
// Input stage: takes transactions and queues them (2 deep).
// ----------------------------------------------------------------------------
module bmfw_front import bmfw_pkg::*; #(
  parameter int W = 35
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         q_valid,
  input  logic         q_ready,
  output logic [W-1:0] q_data
);

  logic [W-1:0] mem [2];
  logic         wp, rp;
  logic [1:0]   cnt;
  logic         push, pop;

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_data   = mem[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_data;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/bmfw_back.sv */
// ----------------------------------------------------------------------------
// bmfw_back
// Execution unit: matrices, witness memory, one pair per cycle unless stalled.
// ----------------------------------------------------------------------------
module bmfw_back import bmfw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  logic [34:0] q_data,
  output logic        o_valid,
  input  logic        o_ready,
  output logic [31:0] o_data,
  output logic        o_last
);

  localparam int DW    = $clog2(DIM);
  localparam int PW    = $clog2(PRODUCTS);
  localparam int AW    = PW + 2 * DW;
  localparam int DEPTH = PRODUCTS * DIM * DIM;
  localparam int EW    = 1 + DW + 6;

  // queue fields
  cmd_t        f_cmd;
  logic [3:0]  f_row, f_col;
  logic [15:0] f_bits;
  logic [2:0]  f_prod, f_lid, f_rid;
  assign f_cmd  = cmd_t'(q_data[1:0]);
  assign f_row  = q_data[5:2];
  assign f_col  = q_data[9:6];
  assign f_bits = q_data[25:10];
  assign f_prod = q_data[28:26];
  assign f_lid  = q_data[31:29];
  assign f_rid  = q_data[34:32];

  logic [DIM-1:0] mat_a [DIM];
  logic [DIM-1:0] mat_b [DIM];
  logic [EW-1:0]  wmem [DEPTH];

  state_t state, state_next;
  logic [DW-1:0]  g, v;
  logic [AW:0]    clr;
  logic [2:0]     prod, lid, rid;
  logic [DIM-1:0] crow;
  logic [3:0]     rd_row;

  // output register
  logic        ob_valid, ob_valid_next;
  logic [31:0] ob_data, ob_data_next;
  logic        ob_last, ob_last_next;
  logic        out_free;
  logic        emit;
  assign o_valid  = ob_valid;
  assign o_data   = ob_data;
  assign o_last   = ob_last;
  assign out_free = !ob_valid || o_ready;

  // column test for (g, v): lowest s with A[g][s] & B[s][v]
  logic [DIM-1:0] hits;
  logic           hit;
  logic [DW-1:0]  smin;
  always_comb begin
    smin = '0;
    for (int s = 0; s < DIM; s++) begin
      hits[s] = mat_a[g][s] & mat_b[s][v];
    end
    for (int s = DIM - 1; s >= 0; s--) begin
      if (hits[s]) smin = DW'(s);
    end
    hit = |hits;
  end

  logic [AW-1:0] maddr;
  assign maddr = {prod, g, v};

  // witness memory pipeline: read old entry, then conditionally write
  logic          p_vld, p_hit;
  logic [AW-1:0] p_addr;
  logic [DW-1:0] p_mid;
  logic [EW-1:0] rd_q;
  logic          last_pair, last_row;
  logic          accept;
  logic          mult_step;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data;

  assign last_pair = (v == DW'(DIM - 1));
  assign last_row  = (g == DW'(DIM - 1));
  assign accept    = (state == ST_IDLE) && q_valid && !p_vld;
  assign mult_step = (state == ST_MULT) && (!last_pair || out_free);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr[AW]) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (f_cmd == CMD_MULT) state_next = ST_MULT;
          else if (f_cmd == CMD_READ) state_next = ST_READ;
        end
      end
      ST_MULT: if (mult_step && last_pair && last_row) state_next = ST_IDLE;
      ST_READ: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == ST_IDLE) && !p_vld;
    emit    = (mult_step && last_pair) || (state == ST_READ && out_free);
    ob_valid_next = emit || (ob_valid && !o_ready);
    ob_data_next = '0;
    ob_last_next = 1'b1;
    if (state == ST_MULT) begin
      ob_data_next[3:0]  = g;
      // bit v of the current pair is not in crow yet
      ob_data_next[19:4] = {hit, crow[DIM-2:0]};
      ob_last_next       = last_row;
    end else begin
      ob_data_next[3:0] = rd_row;
      if (rd_q[EW-1]) ob_data_next[30:20] = {rd_q[2:0], rd_q[5:3], rd_q[9:6], 1'b1};
    end
  end

  // single write port: clearing pass or pending witness write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_addr;
    wr_data = {1'b1, p_mid, lid, rid};
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr[AW-1:0];
      wr_data = '0;
    end else if (p_vld && p_hit && !rd_q[EW-1]) begin
      wr_en = 1'b1;
    end
    rd_en   = (state == ST_MULT) || accept;
    rd_addr = (state == ST_MULT) ? maddr : {f_prod, f_row, f_col};
  end

  always_ff @(posedge clk) begin
    if (wr_en) wmem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= wmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIM; i++) begin
        mat_a[i] <= '0;
        mat_b[i] <= '0;
      end
    end else if (accept) begin
      case (f_cmd)
        CMD_LOAD_A: mat_a[f_row] <= f_bits;
        CMD_LOAD_B: mat_b[f_row] <= f_bits;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod   <= f_prod;
      lid    <= f_lid;
      rid    <= f_rid;
      rd_row <= f_row;
      g      <= '0;
      v      <= '0;
    end else if (mult_step) begin
      crow[v] <= hit;
      if (last_pair) begin
        g <= g + 1'b1;
        v <= '0;
      end else begin
        v <= v + 1'b1;
      end
    end

    p_addr <= maddr;
    p_mid  <= smin;
    p_hit  <= hit;

    if (emit) begin
      ob_data <= ob_data_next;
      ob_last <= ob_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr      <= '0;
      p_vld    <= 1'b0;
      ob_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + 1'b1;
      p_vld    <= mult_step;
      ob_valid <= ob_valid_next;
    end
  end

endmodule

/* rtl/boolean_matmul_first_witness.sv */
// A read fetches its witness entry on acceptance, then registers the answer. A
// multiply visits one (row, column) pair per cycle, stalling at a row's last
// pair until the output register is free; it emits one result row per matrix
// row, then a witness write-back. The witness memory has one read and one write
// port, one entry a cycle each. Reset (rst, sync, active high) clears control
// state and both matrices, then a clearing pass zeroes the witness memory.
// ----------------------------------------------------------------------------
// boolean_matmul_first_witness
// Boolean matrix product with first-witness recording, stream interfaces.
// ----------------------------------------------------------------------------
module boolean_matmul_first_witness (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cmd[1:0]
  input  logic [1:0]  s_tuser,
  // row_index[3:0] col_index[7:4] row_bits[23:8] product_id[26:24]
  // left_id[29:27] right_id[32:30], zero pad
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_row[3:0] product_row[19:4] witness_valid[20] witness_mid[24:21]
  // witness_left[27:25] witness_right[30:28], zero pad
  output logic [31:0] m_tdata,
  output logic        m_tlast
);

  // front queue decouples acceptance from the sequencer
  logic        q_valid, q_ready;
  logic [34:0] q_data;

  bmfw_front #(.W(35)) u_front (
    .clk, .rst,
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  ({s_tdata[32:0], s_tuser}),
    .q_valid, .q_ready, .q_data
  );

  bmfw_back u_back (
    .clk, .rst,
    .q_valid, .q_ready, .q_data,
    .o_valid (m_tvalid),
    .o_ready (m_tready),
    .o_data  (m_tdata),
    .o_last  (m_tlast)
  );

endmodule

/* rtl/bmfw_checker.sv */
// ----------------------------------------------------------------------------
// bmfw_checker
// Port-level checks for boolean_matmul_first_witness.
// ----------------------------------------------------------------------------
module bmfw_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  a_row_wit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[19:4] != 16'd0 |-> m_tdata[31:20] == 12'd0)
    else $error("product row and witness both set");

  a_wit_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[20] |-> m_tdata[31:21] == 11'd0)
    else $error("unset witness with nonzero fields");

  a_wit_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[20] |-> m_tlast)
    else $error("witness answer not marked last");

endmodule

bind boolean_matmul_first_witness bmfw_checker u_chk (.*);
